### rtl/core/gace_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gace_pkg - shared types and helpers of the cut vertex engine
// Request codes, controller/datapath command and status structs, bit count,
// lowest set bit search and live node mask.
// ---------------------------------------------------------------------------
package gace_pkg;

	localparam int ROWS           = 32;
	localparam int NODE_W         = 5;
	localparam int CNT_W          = 6;
	localparam int OP_W           = 3;
	localparam int MAX_NODES      = 32;
	localparam int NODE_COUNT_RST = 32;

	// Request codes
	localparam logic [OP_W-1:0] OP_ADD  = 3'd0;
	localparam logic [OP_W-1:0] OP_REM  = 3'd1;
	localparam logic [OP_W-1:0] OP_DEG  = 3'd2;
	localparam logic [OP_W-1:0] OP_CUT  = 3'd3;
	localparam logic [OP_W-1:0] OP_ROOT = 3'd4;

	typedef enum logic [1:0] {
		RD_A,
		RD_B,
		RD_FRONT,
		RD_SCAN
	} rd_src_t;

	typedef enum logic {
		WR_A,
		WR_B
	} wr_dst_t;

	typedef enum logic [2:0] {
		RES_ERR,
		RES_OK,
		RES_DEG,
		RES_CUT,
		RES_ROOT
	} res_kind_t;

	typedef struct packed {
		logic      load_item;
		logic      rd_en;
		rd_src_t   rd_src;
		logic      wr_en;
		wr_dst_t   wr_dst;
		logic      cut_init;
		logic      walk_step;
		logic      root_init;
		logic      root_step;
		logic      res_ld;
		res_kind_t res_kind;
	} cmd_t;

	typedef struct packed {
		logic [OP_W-1:0] op;
		logic            err;
		logic            walk_done;
		logic            root_done;
	} sts_t;

	// Count set bits, nibble by nibble
	function automatic logic [CNT_W-1:0] popcount32(input logic [ROWS-1:0] v);
		logic [CNT_W-1:0] sum;
		sum = '0;
		for (int k = 0; k < ROWS / 4; k++) begin
			sum = sum + CNT_W'(v[4*k]) + CNT_W'(v[4*k+1])
				+ CNT_W'(v[4*k+2]) + CNT_W'(v[4*k+3]);
		end
		return sum;
	endfunction

	// Index of the lowest set bit, zero for an empty word
	function automatic logic [NODE_W-1:0] lsb_index(input logic [ROWS-1:0] v);
		logic [NODE_W-1:0] idx;
		idx = '0;
		for (int i = ROWS - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = NODE_W'(i);
			end
		end
		return idx;
	endfunction

	// One bit for each node below the live count
	function automatic logic [ROWS-1:0] live_mask(input logic [CNT_W-1:0] n);
		logic [ROWS-1:0] m;
		if (n >= CNT_W'(ROWS)) begin
			m = '1;
		end else begin
			m = (ROWS'(1) << n) - ROWS'(1);
		end
		return m;
	endfunction

endpackage
`default_nettype wire

### rtl/core/gace_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gace_in_if - request channel
// Valid/ready channel carrying one request: op, node_a, node_b.
// ---------------------------------------------------------------------------
interface gace_in_if;
	logic       valid;
	logic       ready;
	logic [2:0] op;
	logic [4:0] node_a;
	logic [4:0] node_b;

	modport source (output valid, output op, output node_a, output node_b, input ready);
	modport sink   (input valid, input op, input node_a, input node_b, output ready);
endinterface
`default_nettype wire

### rtl/core/gace_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gace_out_if - result channel
// Valid/ready channel carrying one result: status, is_cut, degree, root_node.
// ---------------------------------------------------------------------------
interface gace_out_if;
	logic       valid;
	logic       ready;
	logic       status;
	logic       is_cut;
	logic [4:0] degree;
	logic [4:0] root_node;

	modport source (output valid, output status, output is_cut, output degree,
		output root_node, input ready);
	modport sink   (input valid, input status, input is_cut, input degree,
		input root_node, output ready);
endinterface
`default_nettype wire

### rtl/core/gace_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gace_dp - datapath of the cut vertex engine
// Adjacency row memory with per-row valid bits, frontier walk registers,
// degree scan registers, node count register and the result register.
// ---------------------------------------------------------------------------
module gace_dp
	import gace_pkg::*;
(
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [CNT_W-1:0]  cfg_wdata,
	input  wire logic [OP_W-1:0]   in_op,
	input  wire logic [NODE_W-1:0] in_a,
	input  wire logic [NODE_W-1:0] in_b,
	input  wire cmd_t              cmd,
	output sts_t                   sts,
	output logic                   res_status,
	output logic                   res_is_cut,
	output logic [NODE_W-1:0]      res_degree,
	output logic [NODE_W-1:0]      res_root
);

	logic [CNT_W-1:0]  node_count_q;
	logic [OP_W-1:0]   op_q;
	logic [NODE_W-1:0] a_q;
	logic [NODE_W-1:0] b_q;
	logic [CNT_W-1:0]  n_q;

	logic [ROWS-1:0]   mem [ROWS];
	logic [ROWS-1:0]   row_vld_q;
	logic [ROWS-1:0]   rd_data_q;
	logic              rd_vld_q;

	logic [ROWS-1:0]   reached_q;
	logic [ROWS-1:0]   frontier_q;
	logic              pend_q;
	logic [CNT_W-1:0]  scan_q;
	logic [NODE_W-1:0] cmp_idx_q;
	logic [CNT_W-1:0]  best_q;
	logic [NODE_W-1:0] root_q;

	logic [CNT_W-1:0]  live_n;
	logic [ROWS-1:0]   mask;
	logic [ROWS-1:0]   bit_a;
	logic [ROWS-1:0]   bit_b;
	logic [ROWS-1:0]   allowed;
	logic [ROWS-1:0]   row;
	logic [ROWS-1:0]   fresh;
	logic [ROWS-1:0]   fr_nxt;
	logic [NODE_W-1:0] fr_idx;
	logic [ROWS-1:0]   nbrs;
	logic [ROWS-1:0]   start;
	logic              scan_more;
	logic [CNT_W-1:0]  row_cnt;
	logic [NODE_W-1:0] rd_addr;
	logic              rd_go;
	logic [NODE_W-1:0] wr_addr;
	logic [ROWS-1:0]   wr_bit;
	logic [ROWS-1:0]   wr_data;
	logic              a_oob;
	logic              b_oob;
	logic              err;

	// Clamp the node count into 1..MAX_NODES
	always_comb begin
		if (node_count_q == '0) begin
			live_n = CNT_W'(1);
		end else if (node_count_q > CNT_W'(MAX_NODES)) begin
			live_n = CNT_W'(MAX_NODES);
		end else begin
			live_n = node_count_q;
		end
	end

	// Masks and the row just read; unwritten rows read as empty
	assign mask      = live_mask(n_q);
	assign bit_a     = ROWS'(1) << a_q;
	assign bit_b     = ROWS'(1) << b_q;
	assign allowed   = mask & ~bit_a;
	assign row       = rd_vld_q ? rd_data_q : '0;
	assign row_cnt   = popcount32(row & mask);

	// Frontier expansion: merge the pending row, pick the next node to visit
	assign fresh     = pend_q ? (row & allowed & ~reached_q) : '0;
	assign fr_nxt    = frontier_q | fresh;
	assign fr_idx    = lsb_index(fr_nxt);
	assign nbrs      = row & allowed;
	assign start     = nbrs & (~nbrs + ROWS'(1));
	assign scan_more = scan_q < n_q;

	// Read address and gating
	always_comb begin
		case (cmd.rd_src)
			RD_A: begin
				rd_addr = a_q;
				rd_go   = cmd.rd_en;
			end
			RD_B: begin
				rd_addr = b_q;
				rd_go   = cmd.rd_en;
			end
			RD_FRONT: begin
				rd_addr = fr_idx;
				rd_go   = cmd.rd_en && (fr_nxt != '0);
			end
			RD_SCAN: begin
				rd_addr = scan_q[NODE_W-1:0];
				rd_go   = cmd.rd_en && scan_more;
			end
			default: begin
				rd_addr = a_q;
				rd_go   = 1'b0;
			end
		endcase
	end

	// Edge write: set or clear the partner bit in the row just read
	assign wr_addr = (cmd.wr_dst == WR_A) ? a_q : b_q;
	assign wr_bit  = (cmd.wr_dst == WR_A) ? bit_b : bit_a;
	assign wr_data = (op_q == OP_ADD) ? (row | wr_bit) : (row & ~wr_bit);

	// Request check
	assign a_oob = {1'b0, a_q} >= n_q;
	assign b_oob = {1'b0, b_q} >= n_q;
	always_comb begin
		case (op_q)
			OP_ADD, OP_REM: err = a_oob || b_oob || (a_q == b_q);
			OP_DEG, OP_CUT: err = a_oob;
			OP_ROOT:        err = 1'b0;
			default:        err = 1'b1;
		endcase
	end

	assign sts.op        = op_q;
	assign sts.err       = err;
	assign sts.walk_done = (fr_nxt == '0);
	assign sts.root_done = !scan_more && !pend_q;

	// Node count register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= CNT_W'(NODE_COUNT_RST);
		end else if (cfg_we) begin
			node_count_q <= cfg_wdata;
		end
	end

	// Capture the request
	always_ff @(posedge clk) begin
		if (cmd.load_item) begin
			op_q <= in_op;
			a_q  <= in_a;
			b_q  <= in_b;
			n_q  <= live_n;
		end
	end

	// Row memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (cmd.wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_go) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// Row valid bits stand in for clearing the memory
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q <= '0;
			rd_vld_q  <= 1'b0;
		end else begin
			if (cmd.wr_en) begin
				row_vld_q[wr_addr] <= 1'b1;
			end
			if (rd_go) begin
				rd_vld_q <= row_vld_q[rd_addr];
			end
		end
	end

	// Walk and scan state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reached_q  <= '0;
			frontier_q <= '0;
			pend_q     <= 1'b0;
			scan_q     <= '0;
			cmp_idx_q  <= '0;
			best_q     <= '0;
			root_q     <= '0;
		end else if (cmd.cut_init) begin
			pend_q     <= 1'b0;
			reached_q  <= start;
			frontier_q <= start;
		end else if (cmd.walk_step) begin
			reached_q  <= reached_q | fresh;
			frontier_q <= fr_nxt & ~(ROWS'(1) << fr_idx);
			pend_q     <= (fr_nxt != '0);
		end else if (cmd.root_init) begin
			scan_q <= '0;
			best_q <= '0;
			root_q <= '0;
			pend_q <= 1'b0;
		end else if (cmd.root_step) begin
			if (pend_q && (row_cnt > best_q)) begin
				best_q <= row_cnt;
				root_q <= cmp_idx_q;
			end
			if (scan_more) begin
				pend_q    <= 1'b1;
				cmp_idx_q <= scan_q[NODE_W-1:0];
				scan_q    <= scan_q + CNT_W'(1);
			end else begin
				pend_q <= 1'b0;
			end
		end
	end

	// Result register
	always_ff @(posedge clk) begin
		if (cmd.res_ld) begin
			case (cmd.res_kind)
				RES_OK: begin
					res_status <= 1'b0;
					res_is_cut <= 1'b0;
					res_degree <= '0;
					res_root   <= '0;
				end
				RES_DEG: begin
					res_status <= 1'b0;
					res_is_cut <= 1'b0;
					res_degree <= row_cnt[NODE_W-1:0];
					res_root   <= '0;
				end
				RES_CUT: begin
					res_status <= 1'b0;
					res_is_cut <= (popcount32(reached_q) < (n_q - CNT_W'(1)));
					res_degree <= '0;
					res_root   <= '0;
				end
				RES_ROOT: begin
					res_status <= 1'b0;
					res_is_cut <= 1'b0;
					res_degree <= '0;
					res_root   <= root_q;
				end
				default: begin
					res_status <= 1'b1;
					res_is_cut <= 1'b0;
					res_degree <= '0;
					res_root   <= '0;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/core/gace_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// gace_ctrl - sequencer of the cut vertex engine
// Steps each request through decode, memory access, walk or scan, and
// hands the result to the output register when it is free.
// ---------------------------------------------------------------------------
module gace_ctrl
	import gace_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire logic out_ready,
	output logic      out_valid,
	input  wire sts_t sts,
	output cmd_t      cmd
);

	typedef enum logic [2:0] {
		S_IDLE,
		S_DECODE,
		S_EDGE_WA,
		S_EDGE_WB,
		S_CUT_START,
		S_WALK,
		S_ROOT,
		S_DONE
	} state_t;

	state_t    state_q;
	res_kind_t kind_q;
	logic      out_valid_q;
	logic      out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign out_free  = !out_valid_q || out_ready;

	// Commands for the datapath
	always_comb begin
		cmd          = '0;
		cmd.rd_src   = RD_A;
		cmd.wr_dst   = WR_A;
		cmd.res_kind = kind_q;
		case (state_q)
			S_IDLE: begin
				cmd.load_item = in_valid;
			end
			S_DECODE: begin
				cmd.rd_en     = 1'b1;
				cmd.rd_src    = RD_A;
				cmd.root_init = (sts.op == OP_ROOT) && !sts.err;
			end
			S_EDGE_WA: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_dst = WR_A;
				cmd.rd_en  = 1'b1;
				cmd.rd_src = RD_B;
			end
			S_EDGE_WB: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_dst = WR_B;
			end
			S_CUT_START: begin
				cmd.cut_init = 1'b1;
			end
			S_WALK: begin
				cmd.walk_step = 1'b1;
				cmd.rd_en     = 1'b1;
				cmd.rd_src    = RD_FRONT;
			end
			S_ROOT: begin
				cmd.root_step = 1'b1;
				cmd.rd_en     = 1'b1;
				cmd.rd_src    = RD_SCAN;
			end
			S_DONE: begin
				cmd.res_ld = out_free;
			end
			default: begin
				cmd.load_item = 1'b0;
			end
		endcase
	end

	// State, result kind and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			kind_q      <= RES_OK;
			out_valid_q <= 1'b0;
		end else begin
			if (state_q == S_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						state_q <= S_DECODE;
					end
				end
				S_DECODE: begin
					if (sts.err) begin
						kind_q  <= RES_ERR;
						state_q <= S_DONE;
					end else begin
						case (sts.op)
							OP_ADD, OP_REM: begin
								kind_q  <= RES_OK;
								state_q <= S_EDGE_WA;
							end
							OP_DEG: begin
								kind_q  <= RES_DEG;
								state_q <= S_DONE;
							end
							OP_CUT: begin
								kind_q  <= RES_CUT;
								state_q <= S_CUT_START;
							end
							OP_ROOT: begin
								kind_q  <= RES_ROOT;
								state_q <= S_ROOT;
							end
							default: begin
								kind_q  <= RES_ERR;
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_EDGE_WA: begin
					state_q <= S_EDGE_WB;
				end
				S_EDGE_WB: begin
					state_q <= S_DONE;
				end
				S_CUT_START: begin
					state_q <= S_WALK;
				end
				S_WALK: begin
					if (sts.walk_done) begin
						state_q <= S_DONE;
					end
				end
				S_ROOT: begin
					if (sts.root_done) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
`default_nettype wire

### rtl/core/graph_adjacency_cut_vertex_engine.sv
`timescale 1ns / 1ps
`default_nettype none
// ---------------------------------------------------------------------------
// graph_adjacency_cut_vertex_engine - adjacency matrix graph engine
// Edge add/remove, degree, cut node test and root-by-degree over a 32 node
// symmetric adjacency bit matrix held in a row memory.
//
//   channel  | dir | handshake      | payload
//   ---------+-----+----------------+-------------------------------------
//   in_ch    | in  | valid / ready  | op[2:0], node_a[4:0], node_b[4:0]
//   out_ch   | out | valid / ready  | status, is_cut, degree[4:0], root_node[4:0]
//   cfg      | in  | cfg_we         | cfg_wdata[5:0] = node_count
//
// One request at a time. Edge add/remove reads and rewrites both rows, degree
// reads one row, the cut test reads one row from memory per visited node and
// the root query does one row read and bit count per node.
// Reset clears the row valid bits at once; no clearing pass is needed.
// A result waits in the output register while the next request is taken.
// ---------------------------------------------------------------------------
module graph_adjacency_cut_vertex_engine
	import gace_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	gace_in_if.sink               in_ch,
	gace_out_if.source            out_ch,
	input  wire logic             cfg_we,
	input  wire logic [CNT_W-1:0] cfg_wdata
);

	cmd_t cmd;
	sts_t sts;
	logic in_ready;
	logic out_valid;

	assign in_ch.ready  = in_ready;
	assign out_ch.valid = out_valid;

	// Sequencer
	gace_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_ready  (in_ready),
		.out_ready (out_ch.ready),
		.out_valid (out_valid),
		.sts       (sts),
		.cmd       (cmd)
	);

	// Datapath and row memory
	gace_dp u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_op      (in_ch.op),
		.in_a       (in_ch.node_a),
		.in_b       (in_ch.node_b),
		.cmd        (cmd),
		.sts        (sts),
		.res_status (out_ch.status),
		.res_is_cut (out_ch.is_cut),
		.res_degree (out_ch.degree),
		.res_root   (out_ch.root_node)
	);

endmodule
`default_nettype wire

### sim/graph_adjacency_cut_vertex_engine_test.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// graph_adjacency_cut_vertex_engine_test - self-checking bench of the engine
// Drives edge, degree, cut-node and root requests over the request channel,
// changes the node count between phases, checks each result against a shadow
// graph or a fixed table value, with random gaps on both channels but in the last three phases.
// ---------------------------------------------------------------------------
module graph_adjacency_cut_vertex_engine_test;
	import gace_pkg::*;

	localparam int          CYCLE_LIMIT   = 600000;
	localparam int          DRAIN_CYCLES  = 64;
	localparam int          PHASE_ITEMS   = 100;
	localparam int          PHASES        = 9;
	localparam int          REPORT_LIMIT  = 10;

	// Request codes the block must reject
	localparam logic [OP_W-1:0] OP_UNDEF5 = 3'd5;
	localparam logic [OP_W-1:0] OP_UNDEF6 = 3'd6;
	localparam logic [OP_W-1:0] OP_UNDEF7 = 3'd7;

	localparam logic STATUS_OK  = 1'b0;
	localparam logic STATUS_ERR = 1'b1;

	typedef struct packed {
		logic [OP_W-1:0]   op;
		logic [NODE_W-1:0] node_a;
		logic [NODE_W-1:0] node_b;
	} request_t;

	typedef struct packed {
		logic              status;
		logic              is_cut;
		logic [NODE_W-1:0] degree;
		logic [NODE_W-1:0] root_node;
	} result_t;

	typedef enum logic {
		ROW_REQUEST,
		ROW_SET_COUNT
	} row_kind_t;

	typedef struct packed {
		row_kind_t        kind;
		logic [CNT_W-1:0] count;
		request_t         req;
		logic             known;
		result_t          want;
	} stim_row_t;

	localparam result_t WANT_OK     = '{STATUS_OK, 1'b0, 5'd0, 5'd0};
	localparam result_t WANT_REJECT = '{STATUS_ERR, 1'b0, 5'd0, 5'd0};
	localparam result_t WANT_CUT    = '{STATUS_OK, 1'b1, 5'd0, 5'd0};

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [CNT_W-1:0] cfg_wdata;

	gace_in_if  req_ch ();
	gace_out_if res_ch ();

	graph_adjacency_cut_vertex_engine u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (req_ch),
		.out_ch    (res_ch),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// Shadow graph and register
	logic [ROWS-1:0]  adj_model [ROWS];
	logic [CNT_W-1:0] node_count_model;

	result_t     pending_results [$];
	stim_row_t   stim_table [$];
	int unsigned send_idle_pct;
	int unsigned recv_idle_pct;
	int unsigned error_count;
	int unsigned cycle_count;
	int unsigned sent_count;
	int unsigned checked_count;
	int unsigned cut_tests;
	int unsigned cut_found;
	int unsigned count_writes;

	always #10 clk = ~clk;

	// Effective node count: zero acts as one, anything above the row count is clamped
	function automatic int unsigned nodes_in_use();
		int unsigned n;
		n = node_count_model;
		if (n < 1) begin
			n = 1;
		end
		if (n > MAX_NODES) begin
			n = MAX_NODES;
		end
		return n;
	endfunction

	function automatic logic [ROWS-1:0] live_bits(input int unsigned n);
		logic [ROWS-1:0] m;
		if (n >= ROWS) begin
			m = '1;
		end else begin
			m = (ROWS'(1) << n) - ROWS'(1);
		end
		return m;
	endfunction

	// Work out the result of one request and apply it to the shadow graph
	function automatic result_t predict_result(input request_t req);
		result_t         res;
		int unsigned     n;
		int unsigned     best;
		int unsigned     d;
		logic [ROWS-1:0] live;
		logic [ROWS-1:0] allowed;
		logic [ROWS-1:0] nbrs;
		logic [ROWS-1:0] reached;
		logic [ROWS-1:0] frontier;
		logic [ROWS-1:0] next_set;
		n = nodes_in_use();
		live = live_bits(n);
		res = WANT_OK;
		case (req.op)
			OP_ADD, OP_REM: begin
				if (req.node_a >= n || req.node_b >= n || req.node_a == req.node_b) begin
					res.status = STATUS_ERR;
				end else if (req.op == OP_ADD) begin
					adj_model[req.node_a][req.node_b] = 1'b1;
					adj_model[req.node_b][req.node_a] = 1'b1;
				end else begin
					adj_model[req.node_a][req.node_b] = 1'b0;
					adj_model[req.node_b][req.node_a] = 1'b0;
				end
			end
			OP_DEG: begin
				if (req.node_a >= n) begin
					res.status = STATUS_ERR;
				end else begin
					res.degree = NODE_W'($countones(adj_model[req.node_a] & live));
				end
			end
			OP_CUT: begin
				if (req.node_a >= n) begin
					res.status = STATUS_ERR;
				end else begin
					// Walk from the lowest neighbour, never through the tested node
					allowed = live & ~(ROWS'(1) << req.node_a);
					nbrs = adj_model[req.node_a] & allowed;
					reached = '0;
					if (nbrs != '0) begin
						reached = nbrs & (~nbrs + ROWS'(1));
						frontier = reached;
						for (int step = 0; step < ROWS && frontier != '0; step++) begin
							next_set = '0;
							for (int i = 0; i < ROWS; i++) begin
								if (frontier[i]) begin
									next_set = next_set | adj_model[i];
								end
							end
							next_set = next_set & allowed & ~reached;
							reached = reached | next_set;
							frontier = next_set;
						end
					end
					res.is_cut = ($countones(reached) < int'(n) - 1);
				end
			end
			OP_ROOT: begin
				best = $countones(adj_model[0] & live);
				for (int unsigned i = 1; i < n; i++) begin
					d = $countones(adj_model[i] & live);
					if (d > best) begin
						best = d;
						res.root_node = NODE_W'(i);
					end
				end
			end
			default: begin
				res.status = STATUS_ERR;
			end
		endcase
		return res;
	endfunction

	// Random set bit of a row
	function automatic logic [NODE_W-1:0] pick_neighbor(input logic [ROWS-1:0] row);
		int unsigned first;
		int unsigned idx;
		first = $urandom_range(ROWS - 1);
		for (int unsigned k = 0; k < ROWS; k++) begin
			idx = (first + k) % ROWS;
			if (row[idx]) begin
				return NODE_W'(idx);
			end
		end
		return '0;
	endfunction

	// Mostly legal requests; keep the edge count near the node count so cut nodes occur
	function automatic request_t random_request();
		request_t        req;
		int unsigned     n;
		int unsigned     pick;
		int unsigned     edges;
		int unsigned     add_top;
		logic [ROWS-1:0] live;
		n = nodes_in_use();
		live = live_bits(n);
		edges = 0;
		for (int unsigned i = 0; i < n; i++) begin
			edges += $countones(adj_model[i] & live);
		end
		edges = edges / 2;
		add_top = (edges < n) ? 55 : 30;
		pick = $urandom_range(99);
		req.node_a = NODE_W'($urandom_range(n - 1));
		req.node_b = NODE_W'($urandom_range(n - 1));
		if (pick < 8) begin
			req.op = OP_W'($urandom_range(7));
			req.node_a = NODE_W'($urandom_range(31));
			req.node_b = NODE_W'($urandom_range(31));
		end else if (pick < add_top) begin
			req.op = OP_ADD;
			if (n > 1 && req.node_a == req.node_b && $urandom_range(3) != 0) begin
				req.node_b = NODE_W'((req.node_a + 1) % n);
			end
		end else if (pick < 60) begin
			req.op = OP_REM;
			if ((adj_model[req.node_a] & live) != '0 && $urandom_range(3) != 0) begin
				req.node_b = pick_neighbor(adj_model[req.node_a] & live);
			end
		end else if (pick < 72) begin
			req.op = OP_DEG;
		end else if (pick < 92) begin
			req.op = OP_CUT;
		end else begin
			req.op = OP_ROOT;
		end
		return req;
	endfunction

	task automatic row_request(input logic [OP_W-1:0] op, input int unsigned a,
		input int unsigned b, input logic known, input result_t want);
		stim_row_t row;
		row.kind = ROW_REQUEST;
		row.count = '0;
		row.req = '{op, NODE_W'(a), NODE_W'(b)};
		row.known = known;
		row.want = want;
		stim_table = {stim_table, row};
	endtask

	task automatic row_count(input int unsigned value);
		stim_row_t row;
		row = '0;
		row.kind = ROW_SET_COUNT;
		row.count = CNT_W'(value);
		stim_table = {stim_table, row};
	endtask

	// Offer one request, hold it until the transfer, then queue its expected result
	task automatic send_request(input request_t req, input logic known, input result_t want);
		result_t res;
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.op <= req.op;
		req_ch.node_a <= req.node_a;
		req_ch.node_b <= req.node_b;
		@(posedge clk);
		while (!req_ch.ready) begin
			@(posedge clk);
		end
		res = predict_result(req);
		if (known) begin
			res = want;
		end
		if (req.op == OP_CUT && res.status == STATUS_OK) begin
			cut_tests++;
			cut_found += res.is_cut;
		end
		pending_results = {pending_results, res};
		sent_count++;
	endtask

	// Write the node count once the block has delivered everything
	task automatic write_node_count(input logic [CNT_W-1:0] value);
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		node_count_model = value;
		count_writes++;
	endtask

	// Receiver: random back-pressure, check each result transfer
	always @(posedge clk) begin
		result_t got;
		result_t want;
		if (arst_n) begin
			if (res_ch.valid && res_ch.ready) begin
				got = '{res_ch.status, res_ch.is_cut, res_ch.degree, res_ch.root_node};
				if (pending_results.size() == 0) begin
					error_count++;
					if (error_count <= REPORT_LIMIT) begin
						$display("ERROR: unexpected result status=%0d is_cut=%0d degree=%0d root=%0d",
							got.status, got.is_cut, got.degree, got.root_node);
					end
				end else begin
					want = pending_results.pop_front();
					checked_count++;
					if (got.status !== want.status || got.is_cut !== want.is_cut
						|| got.degree !== want.degree || got.root_node !== want.root_node) begin
						error_count++;
						if (error_count <= REPORT_LIMIT) begin
							$display("ERROR: result %0d status %0d/%0d is_cut %0d/%0d degree %0d/%0d root %0d/%0d (exp/got)",
								checked_count, want.status, got.status, want.is_cut, got.is_cut,
								want.degree, got.degree, want.root_node, got.root_node);
						end
					end
				end
			end
			res_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Watchdog
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end
	end

	initial begin
		logic [CNT_W-1:0] phase_counts [PHASES];
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = '0;
		req_ch.valid = 1'b0;
		req_ch.op = OP_ADD;
		req_ch.node_a = '0;
		req_ch.node_b = '0;
		res_ch.ready = 1'b0;
		error_count = 0;
		cycle_count = 0;
		sent_count = 0;
		checked_count = 0;
		cut_tests = 0;
		cut_found = 0;
		count_writes = 0;
		send_idle_pct = 21;
		recv_idle_pct = 84;
		node_count_model = CNT_W'(NODE_COUNT_RST);
		for (int i = 0; i < ROWS; i++) begin
			adj_model[i] = '0;
		end

		// Directed table: empty graph, extremes, rejects, stale edges, count clamping
		row_request(OP_DEG, 0, 0, 1'b1, WANT_OK);
		row_request(OP_ROOT, 0, 0, 1'b1, WANT_OK);
		row_request(OP_CUT, 5, 0, 1'b1, WANT_CUT);
		row_request(OP_ADD, 0, 31, 1'b1, WANT_OK);
		row_request(OP_ADD, 31, 0, 1'b0, WANT_OK);
		row_request(OP_ADD, 5, 5, 1'b1, WANT_REJECT);
		row_request(OP_REM, 3, 3, 1'b1, WANT_REJECT);
		row_request(OP_UNDEF5, 0, 1, 1'b1, WANT_REJECT);
		row_request(OP_UNDEF6, 2, 3, 1'b1, WANT_REJECT);
		row_request(OP_UNDEF7, 31, 31, 1'b1, WANT_REJECT);
		row_request(OP_DEG, 31, 0, 1'b0, WANT_OK);
		row_request(OP_ADD, 0, 1, 1'b0, WANT_OK);
		row_request(OP_ADD, 1, 2, 1'b0, WANT_OK);
		row_request(OP_DEG, 0, 0, 1'b0, WANT_OK);
		row_request(OP_CUT, 0, 0, 1'b0, WANT_OK);
		row_request(OP_REM, 4, 9, 1'b0, WANT_OK);
		row_request(OP_ROOT, 0, 0, 1'b0, WANT_OK);
		row_count(4);
		row_request(OP_DEG, 0, 0, 1'b0, WANT_OK);
		row_request(OP_ADD, 0, 4, 1'b1, WANT_REJECT);
		row_request(OP_DEG, 4, 0, 1'b1, WANT_REJECT);
		row_request(OP_CUT, 1, 0, 1'b0, WANT_OK);
		row_request(OP_ADD, 2, 3, 1'b0, WANT_OK);
		row_request(OP_CUT, 3, 0, 1'b0, WANT_OK);
		row_count(0);
		row_request(OP_CUT, 0, 0, 1'b1, WANT_OK);
		row_request(OP_ADD, 0, 1, 1'b1, WANT_REJECT);
		row_count(63);
		row_request(OP_DEG, 31, 0, 1'b0, WANT_OK);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table
		foreach (stim_table[i]) begin
			if (stim_table[i].kind == ROW_SET_COUNT) begin
				write_node_count(stim_table[i].count);
			end else begin
				send_request(stim_table[i].req, stim_table[i].known, stim_table[i].want);
			end
		end

		// Random phases: small, clamped and full node counts under three idle patterns
		phase_counts = '{6'd32, 6'd2, 6'd5, 6'd63, 6'd8, 6'd0, 6'd12, 6'd1,
			CNT_W'($urandom_range(63))};
		for (int p = 0; p < PHASES; p++) begin
			case (p / 3)
				0: begin
					send_idle_pct = 21;
					recv_idle_pct = 84;
				end
				1: begin
					send_idle_pct = 84;
					recv_idle_pct = 21;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			write_node_count(phase_counts[p]);
			repeat (PHASE_ITEMS) begin
				send_request(random_request(), 1'b0, WANT_OK);
			end
		end

		// Drain
		req_ch.valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
		error_count += pending_results.size();

		$display("Run covered %0d requests and %0d checked results over %0d node count settings.",
			sent_count, checked_count, count_writes);
		$display("Cut tests answered: %0d, of which %0d found a cut node.", cut_tests, cut_found);
		if (error_count == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule
